// File: hw/rtl/clcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg - shared types and constants for the character LCD sequencer
// Request codes, register indexes, init tables and the segment descriptor.
// ----------------------------------------------------------------------------
package clcd_pkg;

   // Width of the loaded wait values and the default countdown width
   localparam int SEG_WAIT_WIDTH     = 16;
   localparam int WAIT_WIDTH_DEFAULT = 16;
   localparam int STEP_WIDTH         = 5;
   localparam int CSR_INDEX_WIDTH    = 3;
   localparam int CSR_DATA_WIDTH     = 16;

   // Request codes carried on the input tuser
   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_INSTR  = 3'd1,
      OP_DATA   = 3'd2,
      OP_CURSOR = 3'd3,
      OP_CLEAR  = 3'd4,
      OP_INIT   = 3'd5
   } op_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ENABLE_HIGH  = 3'd0,
      REG_NIBBLE_GAP   = 3'd1,
      REG_COMMAND_WAIT = 3'd2,
      REG_DATA_WAIT    = 3'd3,
      REG_POWER_UP     = 3'd4
   } reg_index_type;

   // Fixed bytes of the controller instruction set
   localparam logic [7:0] ROW0_BASE     = 8'h80;
   localparam logic [7:0] ROW1_BASE     = 8'hC0;
   localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
   localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_ENTRY     = 8'h06;

   // Power-up wake nibbles and the fixed settle times after each
   localparam logic [3:0] INIT_NIBBLE [4] = '{4'h3, 4'h3, 4'h3, 4'h2};
   localparam logic [SEG_WAIT_WIDTH-1:0] INIT_FIXED_US [4] =
      '{16'd5000, 16'd150, 16'd150, 16'd1000};

   // Configuration as seen by the sequencer
   typedef struct packed {
      logic [7:0]                enable_high_us;
      logic [9:0]                nibble_gap_us;
      logic [SEG_WAIT_WIDTH-1:0] command_wait_us;
      logic [SEG_WAIT_WIDTH-1:0] data_wait_us;
      logic [SEG_WAIT_WIDTH-1:0] power_up_wait_us;
   } cfg_type;

   // One timed pin segment
   typedef struct packed {
      logic                      valid;    // segment exists, sequence goes on
      logic                      en;       // EN level during the segment
      logic                      nib_we;   // segment drives new data pins
      logic [3:0]                nibble;
      logic [SEG_WAIT_WIDTH-1:0] wait_us;
   } seg_type;

   // Segments of one byte: high nibble strobe, gap, low nibble strobe, gap, post wait
   function automatic seg_type byte_seg(input logic [2:0] sub, input logic [7:0] b,
                                        input logic [SEG_WAIT_WIDTH-1:0] post,
                                        input cfg_type cfg);
      seg_type s;
      s         = '0;
      s.valid   = 1'b1;
      s.nibble  = b[7:4];
      case (sub)
         3'd0: begin
            s.en      = 1'b1;
            s.nib_we  = 1'b1;
            s.nibble  = b[7:4];
            s.wait_us = SEG_WAIT_WIDTH'(cfg.enable_high_us);
         end
         3'd1: s.wait_us = SEG_WAIT_WIDTH'(cfg.nibble_gap_us);
         3'd2: begin
            s.en      = 1'b1;
            s.nib_we  = 1'b1;
            s.nibble  = b[3:0];
            s.wait_us = SEG_WAIT_WIDTH'(cfg.enable_high_us);
         end
         3'd3: s.wait_us = SEG_WAIT_WIDTH'(cfg.nibble_gap_us);
         default: s.wait_us = post;
      endcase
      return s;
   endfunction

endpackage

// File: hw/rtl/char_lcd_4bit_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_4bit_sequencer - character LCD driver, 4-bit bus
// Steps timed RS/EN/D7..D4 pin sequences from tick and request transactions.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one transaction per microsecond tick or per request (byte,
//   character, set cursor, clear, init). Each transaction gives exactly one
//   rsp_ transaction with the pin levels after it, the busy flag and whether
//   it started a sequence. Requests that arrive while busy are refused.
//   Order: a taken transaction sits in the input register and its result is
//   registered in the output register once the output is free.
//   Throughput: one transaction per cycle while the output is free; the input
//   register, the state update and the output register form a two-stage pipeline.
//   Stall: while rsp_tready is low the result holds; one more transaction
//   waits in the input register, then req_tready drops.
//   Reset (synchronous): sequencer idle, all pins low, timing registers at
//   their defaults (EN 1, gap 100, command 2000, data 100, power-up 20000).
//   csr_ writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module char_lcd_4bit_sequencer import clcd_pkg::*; #(
   parameter int WAIT_COUNTER_WIDTH = WAIT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,   // byte_value[7:0], row[8], col[14:9]
   input  logic [2:0]                 req_tuser,   // command[2:0]
   // result channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // register_select[0], enable_pin[1],
                                                   // data_nibble[5:2], busy_res[6], accepted[7]
   // configuration
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int W          = WAIT_COUNTER_WIDTH;
   localparam int SAT_WIDTH  = (W > SEG_WAIT_WIDTH) ? W : SEG_WAIT_WIDTH;
   localparam logic [SAT_WIDTH-1:0] WAIT_MAX = SAT_WIDTH'({W{1'b1}});

   cfg_type cfg;
   seg_type seg;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [2:0]            in_cmd_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_row_ff;
   logic [5:0]            in_col_ff;

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_data_ff, out_data_in;

   // sequencer state
   logic                  running_ff, running_in;
   op_type                op_ff, op_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [W-1:0]          wait_ff, wait_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  rs_ff, rs_in;
   logic                  en_ff, en_in;
   logic [3:0]            nib_ff, nib_in;

   logic                  out_free, advance, take;
   logic                  is_tick, is_req, start;
   logic [W-1:0]          wait_dec;
   logic [7:0]            new_byte;
   op_type                op_sel;
   logic [STEP_WIDTH-1:0] step_sel;
   logic [7:0]            byte_sel;
   logic [SAT_WIDTH-1:0]  seg_wait_ext;
   logic [W-1:0]          seg_wait_sat;

   clcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Pipeline flow control
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   // Request classification
   assign is_tick = (in_cmd_ff == OP_TICK);
   assign is_req  = (in_cmd_ff == OP_INSTR) || (in_cmd_ff == OP_DATA) ||
                    (in_cmd_ff == OP_CURSOR) || (in_cmd_ff == OP_CLEAR) ||
                    (in_cmd_ff == OP_INIT);
   assign start   = is_req && !running_ff;
   assign wait_dec = (wait_ff != '0) ? wait_ff - W'(1) : '0;

   // Byte latched by a new request
   always_comb begin
      case (in_cmd_ff)
         OP_INSTR, OP_DATA: new_byte = in_byte_ff;
         OP_CURSOR:         new_byte = (in_row_ff ? ROW1_BASE : ROW0_BASE) + {2'b00, in_col_ff};
         OP_CLEAR:          new_byte = CMD_CLEAR;
         default:           new_byte = '0;
      endcase
   end

   // Segment lookup: first segment on a start, following one on a tick
   assign op_sel   = start ? op_type'(in_cmd_ff) : op_ff;
   assign step_sel = start ? '0 : step_ff + STEP_WIDTH'(1);
   assign byte_sel = start ? new_byte : byte_ff;

   clcd_segment u_segment (
      .op         (op_sel),
      .step       (step_sel),
      .byte_value (byte_sel),
      .cfg        (cfg),
      .seg        (seg)
   );

   // Clamp the loaded wait to the countdown range
   assign seg_wait_ext = SAT_WIDTH'(seg.wait_us);
   assign seg_wait_sat = (seg_wait_ext > WAIT_MAX) ? WAIT_MAX[W-1:0] : seg_wait_ext[W-1:0];

   // Sequencer state update, once per transaction leaving the input register
   always_comb begin
      running_in = running_ff;
      op_in      = op_ff;
      step_in    = step_ff;
      wait_in    = wait_ff;
      byte_in    = byte_ff;
      rs_in      = rs_ff;
      en_in      = en_ff;
      nib_in     = nib_ff;
      if (advance) begin
         if (start) begin
            running_in = 1'b1;
            op_in      = op_sel;
            step_in    = '0;
            byte_in    = new_byte;
            rs_in      = (in_cmd_ff == OP_DATA);
            en_in      = seg.en;
            wait_in    = seg_wait_sat;
            if (seg.nib_we)
               nib_in = seg.nibble;
         end else if (is_tick && running_ff) begin
            if (wait_dec == '0) begin
               if (seg.valid) begin
                  step_in = step_sel;
                  en_in   = seg.en;
                  wait_in = seg_wait_sat;
                  if (seg.nib_we)
                     nib_in = seg.nibble;
               end else begin
                  // sequence done: EN low, RS and data pins hold
                  running_in = 1'b0;
                  en_in      = 1'b0;
                  op_in      = OP_TICK;
                  step_in    = '0;
                  wait_in    = '0;
               end
            end else begin
               wait_in = wait_dec;
            end
         end
      end
   end

   // Input and output register next values
   always_comb begin
      in_valid_in  = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_data_in  = advance ? {start, running_in, nib_in, en_in, rs_in} : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_data_ff  <= '0;
         running_ff   <= 1'b0;
         op_ff        <= OP_TICK;
         step_ff      <= '0;
         wait_ff      <= '0;
         byte_ff      <= '0;
         rs_ff        <= 1'b0;
         en_ff        <= 1'b0;
         nib_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         out_data_ff  <= out_data_in;
         running_ff   <= running_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         wait_ff      <= wait_in;
         byte_ff      <= byte_in;
         rs_ff        <= rs_in;
         en_ff        <= en_in;
         nib_ff       <= nib_in;
      end
   end

   // Input payload register
   always_ff @(posedge clock) begin
      if (take) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata[7:0];
         in_row_ff  <= req_tdata[8];
         in_col_ff  <= req_tdata[14:9];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: hw/rtl/clcd_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_csr - timing configuration registers
// Write-only register file for the pin timing of the LCD sequencer.
// ----------------------------------------------------------------------------
module clcd_csr import clcd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_ENABLE_HIGH:  cfg_in.enable_high_us   = csr_wdata[7:0];
            REG_NIBBLE_GAP:   cfg_in.nibble_gap_us    = csr_wdata[9:0];
            REG_COMMAND_WAIT: cfg_in.command_wait_us  = csr_wdata[15:0];
            REG_DATA_WAIT:    cfg_in.data_wait_us     = csr_wdata[15:0];
            REG_POWER_UP:     cfg_in.power_up_wait_us = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_high_us   <= 8'd1;
         cfg_ff.nibble_gap_us    <= 10'd100;
         cfg_ff.command_wait_us  <= 16'd2000;
         cfg_ff.data_wait_us     <= 16'd100;
         cfg_ff.power_up_wait_us <= 16'd20000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/clcd_segment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_segment - segment decoder
// Maps operation and step number to EN level, data nibble and segment wait.
// ----------------------------------------------------------------------------
module clcd_segment import clcd_pkg::*; (
   input  op_type                  op,
   input  logic [STEP_WIDTH-1:0]   step,
   input  logic [7:0]              byte_value,
   input  cfg_type                 cfg,
   output seg_type                 seg
);

   logic [STEP_WIDTH-1:0] step_m1;
   logic [1:0]            wake_idx;

   assign step_m1  = step - STEP_WIDTH'(1);
   assign wake_idx = step_m1[2:1];

   always_comb begin
      seg = '0;
      unique case (op)
         OP_INSTR, OP_CURSOR: begin
            if (step <= STEP_WIDTH'(4))
               seg = byte_seg(step[2:0], byte_value, cfg.command_wait_us, cfg);
         end
         OP_DATA: begin
            if (step <= STEP_WIDTH'(4))
               seg = byte_seg(step[2:0], byte_value, cfg.data_wait_us, cfg);
         end
         OP_CLEAR: begin
            if (step <= STEP_WIDTH'(4)) begin
               seg = byte_seg(step[2:0], CMD_CLEAR, cfg.command_wait_us, cfg);
            end else if (step == STEP_WIDTH'(5)) begin
               // extra wait for the display clear to finish
               seg.valid   = 1'b1;
               seg.wait_us = cfg.command_wait_us;
            end
         end
         OP_INIT: begin
            if (step == '0) begin
               seg.valid   = 1'b1;
               seg.wait_us = cfg.power_up_wait_us;
            end else if (step <= STEP_WIDTH'(8)) begin
               // wake-up nibbles: strobe, then gap plus fixed settle
               seg.valid = 1'b1;
               if (!step_m1[0]) begin
                  seg.en      = 1'b1;
                  seg.nib_we  = 1'b1;
                  seg.nibble  = INIT_NIBBLE[wake_idx];
                  seg.wait_us = SEG_WAIT_WIDTH'(cfg.enable_high_us);
               end else begin
                  seg.wait_us = SEG_WAIT_WIDTH'(cfg.nibble_gap_us) + INIT_FIXED_US[wake_idx];
               end
            end else if (step <= STEP_WIDTH'(13)) begin
               seg = byte_seg(3'(step - STEP_WIDTH'(9)), CMD_FUNC_SET,
                              cfg.command_wait_us, cfg);
            end else if (step <= STEP_WIDTH'(18)) begin
               seg = byte_seg(3'(step - STEP_WIDTH'(14)), CMD_DISP_ON,
                              cfg.command_wait_us, cfg);
            end else if (step <= STEP_WIDTH'(23)) begin
               seg = byte_seg(3'(step - STEP_WIDTH'(19)), CMD_CLEAR,
                              cfg.command_wait_us, cfg);
            end else if (step == STEP_WIDTH'(24)) begin
               seg.valid   = 1'b1;
               seg.wait_us = cfg.command_wait_us;
            end else if (step <= STEP_WIDTH'(29)) begin
               seg = byte_seg(3'(step - STEP_WIDTH'(25)), CMD_ENTRY,
                              cfg.command_wait_us, cfg);
            end
         end
         default: seg = '0;
      endcase
   end

endmodule

// File: hw/rtl/clcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_checker - port-level checks for the LCD sequencer
// Watches the result channel and flags inconsistent pin and status levels.
// ----------------------------------------------------------------------------
module clcd_checker import clcd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A stalled result transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result payload changed while stalled");

   // A transaction that starts a sequence reports busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> rsp_tdata[6])
      else $error("accepted without busy");

   // EN is never high once the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[6] |-> !rsp_tdata[1])
      else $error("enable high while idle");

   // No result is offered right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind char_lcd_4bit_sequencer clcd_checker u_clcd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
